// ===== sv/prc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prc_pkg
// shared constants, types and the arctangent table of the converter
// ----------------------------------------------------------------------------
package prc_pkg;

  localparam int CORDIC_STAGES_DEF = 24;
  localparam int XW = 44;
  localparam int ZW = 34;

  localparam logic [1:0] FORM_RECT  = 2'd0;
  localparam logic [1:0] FORM_POLAR = 2'd1;

  localparam logic signed [ZW-1:0] PI_Q28      = ZW'(843314857);
  localparam logic signed [ZW-1:0] HALF_PI_Q28 = ZW'(421657428);
  localparam logic [31:0]          GAIN_Q32    = 32'd2608131496;
  localparam logic signed [31:0]   DEG2RAD_Q36 = 32'sd1199381129;
  localparam logic signed [25:0]   FULL_TURN   = 26'sd23592960;
  localparam logic signed [25:0]   HALF_TURN   = 26'sd11796480;
  localparam logic [12:0]          TURN_RECIP  = 13'd5825;

  typedef struct packed {
    logic [1:0]            form;
    logic signed [31:0]    a;
    logic signed [31:0]    b;
    logic signed [31:0]    ang;
    logic                  zero;
    logic signed [XW-1:0]  x;
    logic signed [XW-1:0]  y;
    logic signed [ZW-1:0]  z;
  } prc_beat_t;

  function automatic logic signed [ZW-1:0] atan_q28(input int idx);
    logic signed [ZW-1:0] v;
    case (idx)
      0:  v = ZW'(210828714);
      1:  v = ZW'(124459457);
      2:  v = ZW'(65760959);
      3:  v = ZW'(33381290);
      4:  v = ZW'(16755422);
      5:  v = ZW'(8385879);
      6:  v = ZW'(4193963);
      7:  v = ZW'(2097109);
      8:  v = ZW'(1048571);
      9:  v = ZW'(524287);
      10: v = ZW'(262144);
      11: v = ZW'(131072);
      12: v = ZW'(65536);
      13: v = ZW'(32768);
      14: v = ZW'(16384);
      15: v = ZW'(8192);
      16: v = ZW'(4096);
      17: v = ZW'(2048);
      18: v = ZW'(1024);
      19: v = ZW'(512);
      20: v = ZW'(256);
      21: v = ZW'(128);
      22: v = ZW'(64);
      23: v = ZW'(32);
      24: v = ZW'(16);
      25: v = ZW'(8);
      26: v = ZW'(4);
      27: v = ZW'(2);
      28: v = ZW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/polar_rect_converter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polar_rect_converter_top
// polar / rectangular converter on a chain of cordic cells
//
//   channel  direction  handshake              payload
//   in       sink       in_valid_i/in_stall_o  req_type, first_value, second_value
//   out      source     out_valid_o/out_stall_i x_coord, y_coord, magnitude,
//                                               angle_rad, mode_out, bad_form
//
// one beat accepted per cycle while in_stall_o is low; the chain is made of the
// three front stages, one cell per micro-rotation and two back stages
// the whole chain advances together; it holds only while the output register
// is full and stalled, and in_stall_o follows that
// reset clears the valid bits only
// ----------------------------------------------------------------------------
module polar_rect_converter_top import prc_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         req_type_i,
  input  logic signed [31:0] first_value_i,
  input  logic signed [31:0] second_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] x_coord_o,
  output logic signed [31:0] y_coord_o,
  output logic signed [33:0] magnitude_o,
  output logic signed [31:0] angle_rad_o,
  output logic               mode_out_o,
  output logic               bad_form_o
);

  localparam int N = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;

  logic      en;
  logic      valid_c [N+1];
  prc_beat_t beat_c  [N+1];

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  prc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .form_i  (req_type_i),
    .a_i     (first_value_i),
    .b_i     (second_value_i),
    .valid_o (valid_c[0]),
    .beat_o  (beat_c[0])
  );

  for (genvar g = 0; g < N; g++) begin : g_cell
    prc_cell #(.SHIFT(g)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (valid_c[g]),
      .beat_i  (beat_c[g]),
      .valid_o (valid_c[g+1]),
      .beat_o  (beat_c[g+1])
    );
  end

  prc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (valid_c[N]),
    .beat_i      (beat_c[N]),
    .valid_o     (out_valid_o),
    .x_coord_o   (x_coord_o),
    .y_coord_o   (y_coord_o),
    .magnitude_o (magnitude_o),
    .angle_rad_o (angle_rad_o),
    .mode_out_o  (mode_out_o),
    .bad_form_o  (bad_form_o)
  );

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no beat waiting");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && bad_form_o) |-> (x_coord_o == '0 && y_coord_o == '0 &&
      magnitude_o == '0 && angle_rad_o == '0 && !mode_out_o))
    else $error("bad form beat carries data");

  a_chain_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(valid_c[0]))
    else $error("chain moved while stalled");

endmodule

// ===== sv/prc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prc_front
// angle reduction, gain precompensation and start vector of the cell chain
// ----------------------------------------------------------------------------
module prc_front import prc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [1:0]         form_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic               valid_o,
  output prc_beat_t          beat_o
);

  logic               v1_q, v2_q, v3_q;
  logic [1:0]         form1_q, form2_q;
  logic signed [31:0] a1_q, b1_q, a2_q, b2_q;
  logic               bneg1_q, aneg1_q;
  logic [31:0]        absb1_q;
  logic [44:0]        qp1_q;
  logic signed [62:0] degp1_q;
  logic [63:0]        gp1_q;
  logic signed [25:0] r2_q;
  logic signed [31:0] ang2_q;
  logic signed [XW-1:0] xg2_q;
  prc_beat_t          beat_q;

  logic [31:0]        absb, absa;
  logic [44:0]        qp_d;
  logic signed [62:0] degp_d;
  logic [63:0]        gp_d;

  logic [7:0]         quo;
  logic [32:0]        rem;
  logic signed [25:0] r_d;
  logic signed [62:0] angp;
  logic [40:0]        gmag;
  logic signed [XW-1:0] xg_d;

  logic signed [56:0] zp;
  logic signed [ZW-1:0] zr;
  prc_beat_t          beat_d;
  logic signed [XW-1:0] ax, by;

  always_comb begin
    absb   = b_i[31] ? 32'(-b_i) : 32'(b_i);
    absa   = a_i[31] ? 32'(-a_i) : 32'(a_i);
    qp_d   = 45'(absb) * 45'(TURN_RECIP);
    degp_d = 63'(b_i) * 63'(DEG2RAD_Q36);
    gp_d   = 64'(absa) * 64'(GAIN_Q32);
  end

  // exact remainder by the full turn, then into (-180, 180]
  always_comb begin
    quo = qp1_q[44:37];
    rem = 33'(absb1_q) - 33'(quo) * 33'(FULL_TURN);
    if (rem >= 33'(FULL_TURN)) begin
      rem = rem - 33'(FULL_TURN);
    end
    r_d = bneg1_q ? -26'(rem) : 26'(rem);
    if (r_d > HALF_TURN) begin
      r_d = r_d - FULL_TURN;
    end
    if (r_d <= -HALF_TURN) begin
      r_d = r_d + FULL_TURN;
    end
    angp = (degp1_q + 63'sd8388608) >>> 24;
    gmag = 41'((gp1_q + 64'd8388608) >> 24);
    xg_d = aneg1_q ? -XW'(gmag) : XW'(gmag);
  end

  always_comb begin
    zp = (57'(r2_q) * 57'(DEG2RAD_Q36) + 57'sd8388608) >>> 24;
    zr = ZW'(zp);
    ax = XW'(a2_q) <<< 8;
    by = XW'(b2_q) <<< 8;
    beat_d.form = form2_q;
    beat_d.a    = a2_q;
    beat_d.b    = b2_q;
    beat_d.ang  = ang2_q;
    beat_d.zero = (a2_q == '0) && (b2_q == '0);
    if (form2_q == FORM_POLAR) begin
      beat_d.y = '0;
      if (zr > HALF_PI_Q28) begin
        beat_d.z = zr - PI_Q28;
        beat_d.x = -xg2_q;
      end else if (zr < -HALF_PI_Q28) begin
        beat_d.z = zr + PI_Q28;
        beat_d.x = -xg2_q;
      end else begin
        beat_d.z = zr;
        beat_d.x = xg2_q;
      end
    end else if (ax < 0) begin
      beat_d.z = (by >= 0) ? PI_Q28 : -PI_Q28;
      beat_d.x = -ax;
      beat_d.y = -by;
    end else begin
      beat_d.z = '0;
      beat_d.x = ax;
      beat_d.y = by;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      form1_q <= form_i;
      a1_q    <= a_i;
      b1_q    <= b_i;
      bneg1_q <= b_i[31];
      aneg1_q <= a_i[31];
      absb1_q <= absb;
      qp1_q   <= qp_d;
      degp1_q <= degp_d;
      gp1_q   <= gp_d;
      form2_q <= form1_q;
      a2_q    <= a1_q;
      b2_q    <= b1_q;
      r2_q    <= r_d;
      ang2_q  <= 32'(angp);
      xg2_q   <= xg_d;
      beat_q  <= beat_d;
    end
  end

  assign valid_o = v3_q;
  assign beat_o  = beat_q;

endmodule

// ===== sv/prc_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prc_cell
// one cordic micro-rotation, vectoring or rotating by the form of the beat
// ----------------------------------------------------------------------------
module prc_cell import prc_pkg::*; #(
  parameter int SHIFT = 0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  prc_beat_t beat_i,
  output logic      valid_o,
  output prc_beat_t beat_o
);

  localparam logic signed [ZW-1:0] ATAN = atan_q28(SHIFT);

  logic      valid_q;
  prc_beat_t beat_q, beat_d;
  logic      s;
  logic signed [XW-1:0] dx, dy;

  always_comb begin
    dx = beat_i.y >>> SHIFT;
    dy = beat_i.x >>> SHIFT;
    s  = (beat_i.form == FORM_POLAR) ? (beat_i.z < 0) : (beat_i.y >= 0);
    beat_d   = beat_i;
    beat_d.x = s ? beat_i.x + dx : beat_i.x - dx;
    beat_d.y = s ? beat_i.y - dy : beat_i.y + dy;
    beat_d.z = s ? beat_i.z + ATAN : beat_i.z - ATAN;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      beat_q <= beat_d;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

// ===== sv/prc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prc_back
// gain compensation, rounding and the output register
// ----------------------------------------------------------------------------
module prc_back import prc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  prc_beat_t          beat_i,
  output logic               valid_o,
  output logic signed [31:0] x_coord_o,
  output logic signed [31:0] y_coord_o,
  output logic signed [33:0] magnitude_o,
  output logic signed [31:0] angle_rad_o,
  output logic               mode_out_o,
  output logic               bad_form_o
);

  logic               v1_q, valid_q;
  logic [1:0]         form1_q;
  logic signed [31:0] a1_q, b1_q, ang1_q, z1_q, xr1_q, yr1_q;
  logic               zero1_q;
  logic [63:0]        plo1_q;
  logic [42:0]        phi1_q;

  logic [42:0]        xc;
  logic signed [XW-1:0] xr, yr;

  logic [43:0]        gm;
  logic [43:0]        mr;
  logic signed [31:0] x_d, y_d, ang_d;
  logic signed [33:0] mag_d;
  logic               mode_d, bad_d;
  logic signed [31:0] x_q, y_q, ang_q;
  logic signed [33:0] mag_q;
  logic               mode_q, bad_q;

  always_comb begin
    xc = beat_i.x[XW-1] ? '0 : 43'(beat_i.x);
    xr = (beat_i.x + XW'(128)) >>> 8;
    yr = (beat_i.y + XW'(128)) >>> 8;
  end

  always_comb begin
    gm    = 44'(phi1_q) + 44'((plo1_q + 64'h8000_0000) >> 32);
    mr    = (gm + 44'd128) >> 8;
    x_d   = '0;
    y_d   = '0;
    mag_d = '0;
    ang_d = '0;
    mode_d = 1'b0;
    bad_d  = 1'b0;
    case (form1_q)
      FORM_RECT: begin
        x_d = a1_q;
        y_d = b1_q;
        if (!zero1_q) begin
          mag_d = 34'(mr);
          ang_d = z1_q;
        end
      end
      FORM_POLAR: begin
        x_d    = xr1_q;
        y_d    = yr1_q;
        mag_d  = 34'(a1_q);
        ang_d  = ang1_q;
        mode_d = 1'b1;
      end
      default: begin
        bad_d = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      valid_q <= 1'b0;
    end else if (en_i) begin
      v1_q    <= valid_i;
      valid_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      form1_q <= beat_i.form;
      a1_q    <= beat_i.a;
      b1_q    <= beat_i.b;
      ang1_q  <= beat_i.ang;
      zero1_q <= beat_i.zero;
      z1_q    <= 32'(beat_i.z);
      plo1_q  <= 64'(xc[31:0]) * 64'(GAIN_Q32);
      phi1_q  <= 43'(xc[42:32]) * 43'(GAIN_Q32);
      xr1_q   <= 32'(xr);
      yr1_q   <= 32'(yr);
      x_q     <= x_d;
      y_q     <= y_d;
      mag_q   <= mag_d;
      ang_q   <= ang_d;
      mode_q  <= mode_d;
      bad_q   <= bad_d;
    end
  end

  assign valid_o     = valid_q;
  assign x_coord_o   = x_q;
  assign y_coord_o   = y_q;
  assign magnitude_o = mag_q;
  assign angle_rad_o = ang_q;
  assign mode_out_o  = mode_q;
  assign bad_form_o  = bad_q;

endmodule
